/* hw/rtl/fct_pkg.sv */
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants of the frustum cull tester: opcodes, verdict
// codes, register indexes, plane field layout and the per-transaction control word.
// ----------------------------------------------------------------------------
package fct_pkg;

    // defaults of the top-level parameters
    localparam int NUM_PLANES_DEF      = 6;
    localparam int CORNERS_PER_BOX_DEF = 8;
    localparam int COORD_WIDTH_DEF     = 16;

    // plane register layout: nx, ny, nz in Q1.14 and offset d in Q8.8
    localparam int PLANE_W   = 64;
    localparam int NORM_W    = 16;
    localparam int OFS_W     = 16;
    localparam int NX_LSB    = 0;
    localparam int NY_LSB    = 16;
    localparam int NZ_LSB    = 32;
    localparam int OFS_LSB   = 48;
    localparam int NORM_FRAC = 14;

    localparam int MAX_PLANES = 6;
    localparam int PLANE_NEAR = 4;
    localparam int PLANE_FAR  = 5;

    localparam int MODE_W = 2;

    // corner and behind counters
    localparam int          CNT_W   = 4;
    localparam logic [3:0]  CNT_MAX = 4'd15;

    // opcodes
    localparam int         OP_W      = 2;
    localparam logic [1:0] OP_CORNER = 2'd0;
    localparam logic [1:0] OP_SPHERE = 2'd1;
    localparam logic [1:0] OP_POINT  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // verdicts
    localparam int         VERDICT_W = 2;
    localparam logic [1:0] V_INSIDE  = 2'd0;
    localparam logic [1:0] V_INTER   = 2'd1;
    localparam logic [1:0] V_OUTSIDE = 2'd2;

    // configuration port
    localparam int         CFG_DATA_W = 64;
    localparam int         CFG_ADDR_W = 6;
    localparam int         REG_IDX_W  = 3;
    localparam int         REG_IDX_LSB = 3;
    localparam logic [2:0] REG_PLANE_LEFT   = 3'd0;
    localparam logic [2:0] REG_PLANE_RIGHT  = 3'd1;
    localparam logic [2:0] REG_PLANE_BOTTOM = 3'd2;
    localparam logic [2:0] REG_PLANE_TOP    = 3'd3;
    localparam logic [2:0] REG_PLANE_NEAR   = 3'd4;
    localparam logic [2:0] REG_PLANE_FAR    = 3'd5;
    localparam logic [2:0] REG_ENABLE_MODE  = 3'd6;

    // control word that travels with each transaction along the cells
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             box_end;
        logic [CNT_W-1:0] corner_cnt;
        logic             any_out;
        logic             any_inter;
    } t_ctl;

endpackage

/* hw/rtl/frustum_cull_tester.sv */
// ----------------------------------------------------------------------------
// frustum_cull_tester
// Classifies box corners, spheres and points against the frustum planes.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock cycle while o_stall is low. Each
// passes a chain of NUM_PLANES plane cells, two register stages per cell
// (products, then sum, compare and behind count), followed by the output
// register. Box corners produce a verdict only on the corner with
// last_corner set or on the CORNERS_PER_BOX-th corner; spheres and points
// produce one each; opcode 3 is accepted and dropped. A stall at the output
// freezes the chain behind it. Plane and mode registers may only be written
// while no transaction is in flight.
module frustum_cull_tester #(
    parameter int NUM_PLANES      = fct_pkg::NUM_PLANES_DEF,
    parameter int CORNERS_PER_BOX = fct_pkg::CORNERS_PER_BOX_DEF,
    parameter int COORD_WIDTH     = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input transactions
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [fct_pkg::OP_W-1:0]           i_opcode,
    input  logic signed [COORD_WIDTH-1:0]      i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]      i_pos_y,
    input  logic signed [COORD_WIDTH-1:0]      i_pos_z,
    input  logic [COORD_WIDTH-2:0]             i_radius,
    input  logic                               i_last_corner,
    // results
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [fct_pkg::VERDICT_W-1:0]      o_verdict,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fct_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fct_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fct_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import fct_pkg::*;

    logic [PLANE_W-1:0]   r_plane [MAX_PLANES];
    logic [MODE_W-1:0]    r_mode;
    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_idx;

    logic                          w_valid  [NUM_PLANES+1];
    logic                          w_stall  [NUM_PLANES+1];
    t_ctl                          w_ctl    [NUM_PLANES+1];
    logic signed [COORD_WIDTH-1:0] w_x      [NUM_PLANES+1];
    logic signed [COORD_WIDTH-1:0] w_y      [NUM_PLANES+1];
    logic signed [COORD_WIDTH-1:0] w_z      [NUM_PLANES+1];
    logic [COORD_WIDTH-2:0]        w_rad    [NUM_PLANES+1];
    logic                          w_enable [NUM_PLANES];

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_idx    = paddr[REG_IDX_LSB +: REG_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PLANES; k++) begin
                r_plane[k] <= '0;
            end
            r_mode <= '0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_PLANE_LEFT:   r_plane[0] <= pwdata;
                REG_PLANE_RIGHT:  r_plane[1] <= pwdata;
                REG_PLANE_BOTTOM: r_plane[2] <= pwdata;
                REG_PLANE_TOP:    r_plane[3] <= pwdata;
                REG_PLANE_NEAR:   r_plane[4] <= pwdata;
                REG_PLANE_FAR:    r_plane[5] <= pwdata;
                REG_ENABLE_MODE:  r_mode     <= pwdata[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PLANE_LEFT:   prdata = r_plane[0];
            REG_PLANE_RIGHT:  prdata = r_plane[1];
            REG_PLANE_BOTTOM: prdata = r_plane[2];
            REG_PLANE_TOP:    prdata = r_plane[3];
            REG_PLANE_NEAR:   prdata = r_plane[4];
            REG_PLANE_FAR:    prdata = r_plane[5];
            REG_ENABLE_MODE:  prdata = CFG_DATA_W'(r_mode);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // chain: head, one cell per plane, tail
    // ------------------------------------------------------------------
    fct_head #(
        .CORNERS_PER_BOX (CORNERS_PER_BOX)
    ) u_head (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_opcode      (i_opcode),
        .i_last_corner (i_last_corner),
        .o_stall       (o_stall),
        .o_valid       (w_valid[0]),
        .o_ctl         (w_ctl[0]),
        .i_stall       (w_stall[0])
    );

    assign w_x[0]   = i_pos_x;
    assign w_y[0]   = i_pos_y;
    assign w_z[0]   = i_pos_z;
    assign w_rad[0] = i_radius;

    for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
        // side planes always decide, near and far only when enabled
        if (k == PLANE_NEAR) begin : g_near
            assign w_enable[k] = r_mode[0];
        end else if (k == PLANE_FAR) begin : g_far
            assign w_enable[k] = r_mode[1];
        end else begin : g_side
            assign w_enable[k] = 1'b1;
        end

        fct_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_plane  (r_plane[k]),
            .i_enable (w_enable[k]),
            .i_valid  (w_valid[k]),
            .i_ctl    (w_ctl[k]),
            .i_pos_x  (w_x[k]),
            .i_pos_y  (w_y[k]),
            .i_pos_z  (w_z[k]),
            .i_radius (w_rad[k]),
            .o_stall  (w_stall[k]),
            .o_valid  (w_valid[k+1]),
            .o_ctl    (w_ctl[k+1]),
            .o_pos_x  (w_x[k+1]),
            .o_pos_y  (w_y[k+1]),
            .o_pos_z  (w_z[k+1]),
            .o_radius (w_rad[k+1]),
            .i_stall  (w_stall[k+1])
        );
    end

    fct_tail u_tail (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid[NUM_PLANES]),
        .i_ctl     (w_ctl[NUM_PLANES]),
        .o_stall   (w_stall[NUM_PLANES]),
        .o_valid   (o_valid),
        .o_verdict (o_verdict),
        .i_stall   (i_stall)
    );

endmodule

/* hw/rtl/fct_head.sv */
// ----------------------------------------------------------------------------
// fct_head
// Entry of the cell chain: counts box corners, flags the corner that closes
// a box and drops unused opcodes.
// ----------------------------------------------------------------------------
module fct_head #(
    parameter int CORNERS_PER_BOX = fct_pkg::CORNERS_PER_BOX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [fct_pkg::OP_W-1:0]   i_opcode,
    input  logic                       i_last_corner,
    output logic                       o_stall,
    output logic                       o_valid,
    output fct_pkg::t_ctl              o_ctl,
    input  logic                       i_stall
);
    import fct_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] w_cnt_inc;
    logic             w_end;
    logic             w_accept;

    assign o_stall  = i_stall;
    assign w_accept = i_valid && !i_stall;

    assign w_cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : CNT_W'(r_cnt + 1'b1);
    assign w_end     = i_last_corner || (w_cnt_inc >= CNT_W'(CORNERS_PER_BOX));

    // opcode 3 is taken and vanishes here
    assign o_valid = i_valid && (i_opcode != OP_NONE);

    always_comb begin
        o_ctl            = '0;
        o_ctl.op         = i_opcode;
        o_ctl.box_end    = (i_opcode == OP_CORNER) && w_end;
        o_ctl.corner_cnt = w_cnt_inc;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (w_accept && (i_opcode == OP_CORNER)) begin
            n_cnt = w_end ? '0 : w_cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_below_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(CORNERS_PER_BOX))
        else $error("corner count reached box size without closing the box");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == OP_CORNER) && i_last_corner) |=> (r_cnt == '0))
        else $error("last corner did not clear the corner count");

    a_other_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode != OP_CORNER)) |=> $stable(r_cnt))
        else $error("non-corner transaction changed the corner count");
`endif

endmodule

/* hw/rtl/fct_cell.sv */
// ----------------------------------------------------------------------------
// fct_cell
// One plane of the chain: forms the signed distance of the point over two
// stages, keeps the count of box corners behind the plane and folds its
// outside / intermediate decision into the passing control word.
// ----------------------------------------------------------------------------
module fct_cell #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [fct_pkg::PLANE_W-1:0]       i_plane,
    input  logic                              i_enable,
    input  logic                              i_valid,
    input  fct_pkg::t_ctl                     i_ctl,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_y,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_z,
    input  logic [COORD_WIDTH-2:0]            i_radius,
    output logic                              o_stall,
    output logic                              o_valid,
    output fct_pkg::t_ctl                     o_ctl,
    output logic signed [COORD_WIDTH-1:0]     o_pos_x,
    output logic signed [COORD_WIDTH-1:0]     o_pos_y,
    output logic signed [COORD_WIDTH-1:0]     o_pos_z,
    output logic [COORD_WIDTH-2:0]            o_radius,
    input  logic                              i_stall
);
    import fct_pkg::*;

    localparam int PROD_W   = COORD_WIDTH + NORM_W;
    localparam int OFS_SH_W = OFS_W + NORM_FRAC;
    localparam int SUM_W    = ((PROD_W > OFS_SH_W) ? PROD_W : OFS_SH_W) + 2;
    localparam int EXT_W    = SUM_W + 1;
    localparam int RAD_W    = COORD_WIDTH - 1;

    logic signed [NORM_W-1:0] w_nx;
    logic signed [NORM_W-1:0] w_ny;
    logic signed [NORM_W-1:0] w_nz;
    logic signed [OFS_W-1:0]  w_d;
    logic signed [PROD_W-1:0] w_px;
    logic signed [PROD_W-1:0] w_py;
    logic signed [PROD_W-1:0] w_pz;

    // stage a: products
    logic                          r_a_valid;
    t_ctl                          r_a_ctl;
    logic signed [COORD_WIDTH-1:0] r_a_x;
    logic signed [COORD_WIDTH-1:0] r_a_y;
    logic signed [COORD_WIDTH-1:0] r_a_z;
    logic [RAD_W-1:0]              r_a_rad;
    logic signed [PROD_W-1:0]      r_px;
    logic signed [PROD_W-1:0]      r_py;
    logic signed [PROD_W-1:0]      r_pz;

    // stage b: decision and behind count
    logic                          r_b_valid;
    t_ctl                          r_b_ctl;
    logic signed [COORD_WIDTH-1:0] r_b_x;
    logic signed [COORD_WIDTH-1:0] r_b_y;
    logic signed [COORD_WIDTH-1:0] r_b_z;
    logic [RAD_W-1:0]              r_b_rad;
    logic [CNT_W-1:0]              r_count;

    logic                    w_load_a;
    logic                    w_load_b;
    logic signed [SUM_W-1:0] w_dist;
    logic signed [EXT_W-1:0] w_rad_sc;
    logic signed [EXT_W-1:0] w_hi;
    logic signed [EXT_W-1:0] w_lo;
    logic                    w_behind;
    logic [CNT_W-1:0]        w_cnt_inc;
    t_ctl                    n_ctl;
    logic [CNT_W-1:0]        n_count;

    assign w_nx = $signed(i_plane[NX_LSB +: NORM_W]);
    assign w_ny = $signed(i_plane[NY_LSB +: NORM_W]);
    assign w_nz = $signed(i_plane[NZ_LSB +: NORM_W]);
    assign w_d  = $signed(i_plane[OFS_LSB +: OFS_W]);

    assign w_px = PROD_W'(w_nx) * PROD_W'(i_pos_x);
    assign w_py = PROD_W'(w_ny) * PROD_W'(i_pos_y);
    assign w_pz = PROD_W'(w_nz) * PROD_W'(i_pos_z);

    assign w_load_b = !r_b_valid || !i_stall;
    assign w_load_a = !r_a_valid || w_load_b;
    assign o_stall  = !w_load_a;

    // distance in Q.22, offset lifted to the product scale
    assign w_dist = SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz)
                  + (SUM_W'(w_d) <<< NORM_FRAC);
    assign w_rad_sc = $signed(EXT_W'({r_a_rad, {NORM_FRAC{1'b0}}}));
    assign w_hi     = EXT_W'(w_dist) + w_rad_sc;
    assign w_lo     = EXT_W'(w_dist) - w_rad_sc;
    assign w_behind = w_dist[SUM_W-1];

    assign w_cnt_inc = (w_behind && (r_count != CNT_MAX)) ? CNT_W'(r_count + 1'b1) : r_count;

    always_comb begin
        n_ctl   = r_a_ctl;
        n_count = r_count;
        case (r_a_ctl.op)
            OP_CORNER: begin
                n_count = w_cnt_inc;
                if (r_a_ctl.box_end) begin
                    n_count = '0;
                    if (i_enable && (w_cnt_inc == r_a_ctl.corner_cnt)) begin
                        n_ctl.any_out = 1'b1;
                    end
                    if (i_enable && (w_cnt_inc != '0)) begin
                        n_ctl.any_inter = 1'b1;
                    end
                end
            end
            OP_SPHERE: begin
                if (i_enable && w_hi[EXT_W-1]) begin
                    n_ctl.any_out = 1'b1;
                end
                if (i_enable && w_lo[EXT_W-1]) begin
                    n_ctl.any_inter = 1'b1;
                end
            end
            OP_POINT: begin
                if (i_enable && w_behind) begin
                    n_ctl.any_out = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_load_a) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_a && i_valid) begin
            r_a_ctl <= i_ctl;
            r_a_x   <= i_pos_x;
            r_a_y   <= i_pos_y;
            r_a_z   <= i_pos_z;
            r_a_rad <= i_radius;
            r_px    <= w_px;
            r_py    <= w_py;
            r_pz    <= w_pz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_count   <= '0;
        end else if (w_load_b) begin
            r_b_valid <= r_a_valid;
            if (r_a_valid) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_b && r_a_valid) begin
            r_b_ctl <= n_ctl;
            r_b_x   <= r_a_x;
            r_b_y   <= r_a_y;
            r_b_z   <= r_a_z;
            r_b_rad <= r_a_rad;
        end
    end

    assign o_valid  = r_b_valid;
    assign o_ctl    = r_b_ctl;
    assign o_pos_x  = r_b_x;
    assign o_pos_y  = r_b_y;
    assign o_pos_z  = r_b_z;
    assign o_radius = r_b_rad;

`ifndef NO_ASSERTIONS
    a_box_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_b && r_a_valid && (r_a_ctl.op == OP_CORNER) && r_a_ctl.box_end)
        |=> (r_count == '0))
        else $error("behind count not cleared at end of box");

    a_non_corner_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_b && r_a_valid && (r_a_ctl.op != OP_CORNER)) |=> $stable(r_count))
        else $error("sphere or point changed the behind count");

    a_open_box_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && (r_b_ctl.op == OP_CORNER) && !r_b_ctl.box_end)
        |-> (!r_b_ctl.any_out && !r_b_ctl.any_inter))
        else $error("verdict flag set on a corner that does not close its box");
`endif

endmodule

/* hw/rtl/fct_tail.sv */
// ----------------------------------------------------------------------------
// fct_tail
// End of the cell chain: turns the collected flags into a verdict, drops
// corners that do not close a box and holds the result in the output register.
// ----------------------------------------------------------------------------
module fct_tail (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  fct_pkg::t_ctl                   i_ctl,
    output logic                            o_stall,
    output logic                            o_valid,
    output logic [fct_pkg::VERDICT_W-1:0]   o_verdict,
    input  logic                            i_stall
);
    import fct_pkg::*;

    logic                 r_valid;
    logic [VERDICT_W-1:0] r_verdict;
    logic                 w_load;
    logic                 w_result;
    logic [VERDICT_W-1:0] w_verdict;

    assign w_load   = !r_valid || !i_stall;
    assign o_stall  = !w_load;
    assign w_result = (i_ctl.op != OP_CORNER) || i_ctl.box_end;

    always_comb begin
        if (i_ctl.any_out) begin
            w_verdict = V_OUTSIDE;
        end else if (i_ctl.any_inter) begin
            w_verdict = V_INTER;
        end else begin
            w_verdict = V_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid && w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid && w_result) begin
            r_verdict <= w_verdict;
        end
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the frustum cull tester. A driver feeds box corners,
// spheres, points and dropped opcodes from a queue; an in-bench model keeps
// its own plane registers and box counts and predicts each verdict, which a
// monitor checks in order. Plane sets change between phases over the APB port.
// ----------------------------------------------------------------------------
module tb_top;
    import fct_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam logic [NORM_W-1:0] N_POS = 16'h4000;  // +1.0 in Q1.14
    localparam logic [NORM_W-1:0] N_NEG = 16'hC000;  // -1.0 in Q1.14
    localparam int SETTLE = 2 * NUM_PLANES_DEF + 8;

    typedef struct {
        logic [OP_W-1:0]      op;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [CW-2:0]        rad;
        logic                 last;
    } t_shape;

    typedef enum {PL_AXIS, PL_SKEWED, PL_RAW, PL_EXTREME} t_plane_set;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [OP_W-1:0]         i_opcode = OP_NONE;
    logic signed [CW-1:0]    i_pos_x = '0;
    logic signed [CW-1:0]    i_pos_y = '0;
    logic signed [CW-1:0]    i_pos_z = '0;
    logic [CW-2:0]           i_radius = '0;
    logic                    i_last_corner = 1'b0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [VERDICT_W-1:0]    o_verdict;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr = '0;
    logic [CFG_DATA_W-1:0]   pwdata = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    frustum_cull_tester uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_radius(i_radius), .i_last_corner(i_last_corner),
        .o_valid(o_valid), .i_stall(i_stall), .o_verdict(o_verdict),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // bench copy of the block state
    logic [PLANE_W-1:0] plane_regs [MAX_PLANES];
    logic [MODE_W-1:0]  mode_reg;
    int unsigned        behind_cnt [MAX_PLANES];
    int unsigned        corner_cnt;

    t_shape             pending_shapes [$];
    logic [1:0]         expected_verdicts [$];
    t_shape             cur_shape;
    int                 shapes_issued;
    int                 shapes_taken;
    int                 real_shapes;
    int                 errors;
    int                 span;
    bit                 calm_in;
    bit                 calm_out;
    int                 gap_left;
    int                 stall_left;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic bit plane_on(input int i);
        if (i >= NUM_PLANES_DEF) return 1'b0;
        if (i == PLANE_NEAR) return mode_reg[0];
        if (i == PLANE_FAR) return mode_reg[1];
        return 1'b1;
    endfunction

    // signed distance in Q.22
    function automatic longint plane_distance(input int i, input t_shape s);
        logic signed [NORM_W-1:0] nx, ny, nz;
        logic signed [OFS_W-1:0]  d;
        nx = plane_regs[i][NX_LSB +: NORM_W];
        ny = plane_regs[i][NY_LSB +: NORM_W];
        nz = plane_regs[i][NZ_LSB +: NORM_W];
        d  = plane_regs[i][OFS_LSB +: OFS_W];
        return longint'(nx) * longint'(s.x) + longint'(ny) * longint'(s.y)
             + longint'(nz) * longint'(s.z) + (longint'(d) <<< NORM_FRAC);
    endfunction

    task automatic classify_shape(input t_shape s);
        logic [1:0] v;
        longint     pdist;
        longint     rad;
        bit         done;
        v = V_INSIDE;
        done = 1'b0;
        rad = longint'({1'b0, s.rad});
        rad = rad <<< NORM_FRAC;
        case (s.op)
            OP_CORNER: begin
                for (int i = 0; i < MAX_PLANES; i++)
                    if (plane_distance(i, s) < 0 && behind_cnt[i] < CNT_MAX)
                        behind_cnt[i]++;
                if (corner_cnt < CNT_MAX) corner_cnt++;
                if (s.last || corner_cnt >= CORNERS_PER_BOX_DEF) begin
                    for (int i = 0; i < MAX_PLANES; i++) begin
                        if (!done && plane_on(i)) begin
                            if (behind_cnt[i] == corner_cnt) begin
                                v = V_OUTSIDE;
                                done = 1'b1;
                            end else if (behind_cnt[i] != 0) begin
                                v = V_INTER;
                            end
                        end
                    end
                    for (int i = 0; i < MAX_PLANES; i++) behind_cnt[i] = 0;
                    corner_cnt = 0;
                    expected_verdicts.push_back(v);
                end
            end
            OP_SPHERE: begin
                for (int i = 0; i < MAX_PLANES; i++) begin
                    if (!done && plane_on(i)) begin
                        pdist = plane_distance(i, s);
                        if (pdist + rad < 0) begin
                            v = V_OUTSIDE;
                            done = 1'b1;
                        end else if (pdist - rad < 0) begin
                            v = V_INTER;
                        end
                    end
                end
                expected_verdicts.push_back(v);
            end
            OP_POINT: begin
                for (int i = 0; i < MAX_PLANES; i++)
                    if (plane_on(i) && plane_distance(i, s) < 0) v = V_OUTSIDE;
                expected_verdicts.push_back(v);
            end
            default: ;
        endcase
    endtask

    function automatic int pick_idle(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                classify_shape(cur_shape);
                shapes_taken++;
            end
            if (i_valid && o_stall) begin
                // payload held until the transaction is taken
            end else if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_shapes.size() != 0) begin
                cur_shape = pending_shapes.pop_front();
                i_opcode      <= cur_shape.op;
                i_pos_x       <= cur_shape.x;
                i_pos_y       <= cur_shape.y;
                i_pos_z       <= cur_shape.z;
                i_radius      <= cur_shape.rad;
                i_last_corner <= cur_shape.last;
                i_valid       <= 1'b1;
                gap_left = pick_idle(calm_in);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic [1:0] want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: verdict %0d with none expected", $time, o_verdict);
                    errors++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_verdict !== want) begin
                        $display("%0t: verdict expected %0d actual %0d", $time, want, o_verdict);
                        errors++;
                    end
                end
            end
            if (stall_left != 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                stall_left = pick_idle(calm_out);
            end
        end
    end

    function automatic logic signed [CW-1:0] sat16(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] pick_coord();
        if ($urandom_range(0, 9) < 7)
            return sat16(int'($urandom_range(0, 2 * span)) - span);
        return $signed(CW'($urandom));
    endfunction

    function automatic t_shape mk(input logic [OP_W-1:0] op, input int x, input int y,
                                  input int z, input int rad, input bit last);
        t_shape s;
        s.op = op;
        s.x = sat16(x);
        s.y = sat16(y);
        s.z = sat16(z);
        s.rad = rad[CW-2:0];
        s.last = last;
        return s;
    endfunction

    function automatic t_shape pick_solo();
        t_shape s;
        s.op = ($urandom_range(0, 1) == 0) ? OP_SPHERE : OP_POINT;
        s.x = pick_coord();
        s.y = pick_coord();
        s.z = pick_coord();
        if ($urandom_range(0, 9) < 7)
            s.rad = (span > 32767) ? 15'h7FFF : (CW-1)'($urandom_range(0, span));
        else s.rad = (CW-1)'($urandom_range(0, 32767));
        s.last = ($urandom_range(0, 1) == 1);
        return s;
    endfunction

    task automatic add_shape(input t_shape s);
        pending_shapes.push_back(s);
        shapes_issued++;
        if (s.op != OP_NONE) real_shapes++;
    endtask

    // tidy boxes have up to eight corners and a proper end; others are noise
    task automatic add_box(input bit tidy);
        int  n, cx, cy, cz, ex, ey, ez;
        bit  auto_end;
        bit  last;
        cx = pick_coord();
        cy = pick_coord();
        cz = pick_coord();
        ex = $urandom_range(0, span / 2);
        ey = $urandom_range(0, span / 2);
        ez = $urandom_range(0, span / 2);
        n = tidy ? $urandom_range(1, CORNERS_PER_BOX_DEF) : $urandom_range(1, 12);
        auto_end = (n == CORNERS_PER_BOX_DEF) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < n; k++) begin
            if (tidy && k > 0 && $urandom_range(0, 9) == 0) add_shape(pick_solo());
            last = tidy ? (k == n - 1 && !auto_end) : ($urandom_range(0, 3) == 0);
            add_shape(mk(OP_CORNER, (k & 1) ? cx + ex : cx - ex, (k & 2) ? cy + ey : cy - ey,
                         (k & 4) ? cz + ez : cz - ez, $urandom_range(0, 32767), last));
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << REG_IDX_LSB;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ENABLE_MODE) mode_reg = value[MODE_W-1:0];
        else plane_regs[idx] = value;
    endtask

    function automatic logic [PLANE_W-1:0] skewed_plane();
        logic [NORM_W-1:0] nx, ny, nz;
        nx = NORM_W'(int'($urandom_range(0, 32768)) - 16384);
        ny = NORM_W'(int'($urandom_range(0, 32768)) - 16384);
        nz = NORM_W'(int'($urandom_range(0, 32768)) - 16384);
        return {sat16(int'($urandom_range(0, 2 * span)) - span), nz, ny, nx};
    endfunction

    function automatic logic [PLANE_W-1:0] extreme_plane();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return 64'h8000_8000_8000_8000;
            3: return 64'h7FFF_7FFF_7FFF_7FFF;
            default: return 64'h8000_7FFF_8000_7FFF;
        endcase
    endfunction

    task automatic load_planes(input t_plane_set kind, input logic [MODE_W-1:0] mode);
        logic [PLANE_W-1:0] p [MAX_PLANES];
        logic [OFS_W-1:0]   h;
        h = OFS_W'($urandom_range(256, 8192));
        span = (kind == PL_AXIS) ? int'(h) + int'(h) / 2 : int'($urandom_range(256, 16384));
        for (int i = 0; i < MAX_PLANES; i++) begin
            case (kind)
                PL_SKEWED: p[i] = skewed_plane();
                PL_RAW:    p[i] = {$urandom, $urandom};
                PL_EXTREME: p[i] = extreme_plane();
                default:   p[i] = '0;
            endcase
        end
        if (kind == PL_AXIS) begin
            // axis-aligned cube of half-size h around the origin
            p[0] = {h, 16'h0, 16'h0, N_POS};
            p[1] = {h, 16'h0, 16'h0, N_NEG};
            p[2] = {h, 16'h0, N_POS, 16'h0};
            p[3] = {h, 16'h0, N_NEG, 16'h0};
            p[4] = {h, N_POS, 16'h0, 16'h0};
            p[5] = {h, N_NEG, 16'h0, 16'h0};
        end
        write_reg(REG_PLANE_LEFT,   p[0]);
        write_reg(REG_PLANE_RIGHT,  p[1]);
        write_reg(REG_PLANE_BOTTOM, p[2]);
        write_reg(REG_PLANE_TOP,    p[3]);
        write_reg(REG_PLANE_NEAR,   p[4]);
        write_reg(REG_PLANE_FAR,    p[5]);
        write_reg(REG_ENABLE_MODE,  CFG_DATA_W'(mode));
    endtask

    // corners give no verdict, so let the pipeline run dry before a write
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (shapes_taken != shapes_issued || expected_verdicts.size() != 0)
            @(posedge i_clk);
        while (quiet < SETTLE) begin
            @(posedge i_clk);
            if (!i_stall) quiet++;
        end
    endtask

    initial begin
        int target;
        for (int i = 0; i < MAX_PLANES; i++) begin
            plane_regs[i] = '0;
            behind_cnt[i] = 0;
        end
        mode_reg = '0;
        corner_cnt = 0;
        shapes_issued = 0;
        shapes_taken = 0;
        real_shapes = 0;
        errors = 0;
        span = 2560;
        calm_in = 1'b0;
        calm_out = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all planes zero: every distance is zero
        add_shape(mk(OP_POINT, 0, 0, 0, 0, 0));
        add_shape(mk(OP_SPHERE, 0, 0, 0, 256, 1));
        add_shape(mk(OP_SPHERE, 32767, -32768, 32767, 0, 0));
        add_shape(mk(OP_CORNER, -32768, 32767, -32768, 32767, 1));
        add_shape(mk(OP_NONE, 1234, -1234, 77, 99, 1));
        wait_idle();

        write_reg(REG_PLANE_LEFT,   {16'd2560, 16'h0, 16'h0, N_POS});
        write_reg(REG_PLANE_RIGHT,  {16'd2560, 16'h0, 16'h0, N_NEG});
        write_reg(REG_PLANE_BOTTOM, {16'd2560, 16'h0, N_POS, 16'h0});
        write_reg(REG_PLANE_TOP,    {16'd2560, 16'h0, N_NEG, 16'h0});
        write_reg(REG_PLANE_NEAR,   {16'd2560, N_POS, 16'h0, 16'h0});
        write_reg(REG_PLANE_FAR,    {16'd2560, N_NEG, 16'h0, 16'h0});
        write_reg(REG_ENABLE_MODE,  CFG_DATA_W'(2'b11));
        add_shape(mk(OP_POINT, 0, 0, 0, 0, 0));
        add_shape(mk(OP_POINT, 32767, 0, 0, 0, 0));
        add_shape(mk(OP_POINT, -32768, -32768, -32768, 0, 0));
        add_shape(mk(OP_POINT, -2560, 0, 0, 0, 0));  // exactly on the plane
        add_shape(mk(OP_SPHERE, 3000, 0, 0, 512, 0));
        add_shape(mk(OP_SPHERE, 0, 0, 0, 32767, 0));
        add_shape(mk(OP_SPHERE, 20000, 0, 0, 0, 0));
        add_shape(mk(OP_SPHERE, 20000, 20000, 20000, 32767, 0));
        // eight corners with no end flag: the count closes the box
        for (int k = 0; k < CORNERS_PER_BOX_DEF; k++) begin
            if (k == 3) add_shape(mk(OP_POINT, 100, 100, 100, 0, 1));
            add_shape(mk(OP_CORNER, (k & 1) ? 3000 : -3000, (k & 2) ? 1000 : -1000,
                         (k & 4) ? 1000 : -1000, 0, 0));
        end
        add_shape(mk(OP_CORNER, 5000, 0, 0, 0, 0));
        add_shape(mk(OP_CORNER, 6000, 100, -100, 0, 1));
        add_shape(mk(OP_CORNER, 10, 20, 30, 0, 1));
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            load_planes(t_plane_set'((phase / 4 + phase) % 4), MODE_W'(phase % 4));
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            target = real_shapes + 138;
            while (real_shapes < target) begin
                case ($urandom_range(0, 99)) inside
                    [0:54]:  add_box(1'b1);
                    [55:74]: add_shape(pick_solo());
                    [75:89]: add_shape(pick_solo());
                    [90:94]: add_shape(mk(OP_NONE, $urandom, $urandom, $urandom,
                                          $urandom, $urandom_range(0, 1)));
                    default: add_box(1'b0);
                endcase
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/fct_pkg.sv
hw/rtl/fct_head.sv
hw/rtl/fct_cell.sv
hw/rtl/fct_tail.sv
hw/rtl/frustum_cull_tester.sv
test/tb_top.sv
